/* hw/rtl/wtca_pkg.sv */
// Shared types and constants of the write throttle credit accounting unit.
// Holds the request codes, register indexes, state encoding and the
// command and status structs between the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package wtca_pkg;

  localparam int unsigned AMT_W = 48;
  localparam int unsigned CNT_W = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [AMT_W-1:0] MINIMUM_RESET = 48'd33554432;

  typedef enum logic [1:0] {
    REQ_RESERVE  = 2'd0,
    REQ_RELEASE  = 2'd1,
    REQ_SCHEDULE = 2'd2,
    REQ_PRESSURE = 2'd3
  } wtca_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THROTTLE_OFF   = 2'd0,
    REG_LIMIT_OVERRIDE = 2'd1,
    REG_LIMIT_MINIMUM  = 2'd2,
    REG_UNUSED         = 2'd3
  } wtca_reg_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOAD   = 7'b0000010,
    S_CALC   = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_SUM    = 7'b0010000,
    S_LIMIT  = 7'b0100000,
    S_DONE   = 7'b1000000
  } wtca_state_e;

  typedef struct packed {
    logic latch;
    logic load;
    logic calc;
    logic update;
    logic sum_step;
    logic apply_limit;
    logic out_load;
  } wtca_cmd_t;

  typedef struct packed {
    logic is_pressure;
    logic at_minimum;
    logic sum_last;
  } wtca_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/wtca_ctrl.sv */
// Sequencer of the write throttle credit accounting unit.
// Steps one request through load, compute, update or sweep; uses wtca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtca_ctrl
  import wtca_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire wtca_stat_t stat_i,
  output wtca_cmd_t       cmd_o
);

  wtca_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        if (!stat_i.is_pressure) begin
          state_d = S_CALC;
        end else if (stat_i.at_minimum) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SUM;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_DONE;
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (stat_i.sum_last) begin
          state_d = S_LIMIT;
        end
      end
      S_LIMIT: begin
        cmd_o.apply_limit = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wtca_dp.sv */
// Datapath of the write throttle credit accounting unit: configuration
// registers, per-slot counters, adaptive limit and result registers.
// Driven by commands from wtca_ctrl; uses wtca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtca_dp
  import wtca_pkg::*;
#(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [AMT_W-1:0]     cfg_data_i,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [1:0]           group_slot_i,
  input  wire logic [AMT_W-1:0]     amount_i,
  input  wire wtca_cmd_t            cmd_i,
  output wtca_stat_t                stat_o,
  output logic                      refused_o,
  output logic                      delay_tick_o,
  output logic [AMT_W-1:0]          current_limit_o
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned IW = SW + 1;
  localparam logic [IW-1:0] SWEEP_LAST = IW'(2 * SLOTS - 1);

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  logic             throttle_off_q;
  logic [AMT_W-1:0] override_q;
  logic [AMT_W-1:0] minimum_q;
  logic [AMT_W-1:0] adaptive_q;

  logic [CNT_W-1:0] res_mem [SLOTS];
  logic [CNT_W-1:0] sch_mem [SLOTS];

  wtca_req_e        type_q;
  logic [SW-1:0]    slot_q;
  logic [AMT_W-1:0] amount_q;
  logic [CNT_W-1:0] res_q, sch_q, usage_q, total_q;
  logic [AMT_W-1:0] lim_q, lim78_q;
  logic [IW-1:0]    idx_q;
  logic             refused_q, delay_q;
  logic             out_refused_q, out_delay_q;
  logic [AMT_W-1:0] out_limit_q;

  logic [2:0]       slot_mod;
  logic [SW-1:0]    rd_slot;
  logic [CNT_W-1:0] rd_res, rd_sch, sweep_val;
  logic [CNT_W-1:0] res_plus, res_minus, sch_plus;
  logic             check_on, refuse, delay;
  logic [CNT_W-3:0] quarter;
  logic [AMT_W-1:0] lim_new;

  always_comb begin
    slot_mod = {1'b0, group_slot_i};
    if (SLOTS < 4 && int'(slot_mod) >= SLOTS) begin
      slot_mod = slot_mod - 3'(SLOTS);
    end
    if (SLOTS < 4 && int'(slot_mod) >= SLOTS) begin
      slot_mod = slot_mod - 3'(SLOTS);
    end
  end

  assign rd_slot   = cmd_i.sum_step ? idx_q[IW-1:1] : slot_q;
  assign rd_res    = res_mem[rd_slot];
  assign rd_sch    = sch_mem[rd_slot];
  assign sweep_val = idx_q[0] ? rd_res : rd_sch;

  assign res_plus  = sat_add(res_q, {{(CNT_W-AMT_W){1'b0}}, amount_q});
  assign res_minus = (res_q > {{(CNT_W-AMT_W){1'b0}}, amount_q}) ?
                     res_q - {{(CNT_W-AMT_W){1'b0}}, amount_q} : '0;
  assign sch_plus  = sat_add(sch_q, {{(CNT_W-AMT_W){1'b0}}, amount_q});

  assign check_on = (lim_q != '0) && (usage_q != '0);
  assign refuse   = check_on && (usage_q > {{(CNT_W-AMT_W){1'b0}}, lim_q});
  assign delay    = check_on && (usage_q > {{(CNT_W-AMT_W){1'b0}}, lim78_q});

  always_comb begin
    quarter = total_q[CNT_W-1:2];
    if ({{(CNT_W-2-AMT_W){1'b0}}, adaptive_q} < quarter) begin
      lim_new = adaptive_q;
    end else begin
      lim_new = quarter[AMT_W-1:0];
    end
    if (lim_new < minimum_q) begin
      lim_new = minimum_q;
    end
  end

  assign stat_o.is_pressure = (type_q == REQ_PRESSURE);
  assign stat_o.at_minimum  = (adaptive_q == minimum_q);
  assign stat_o.sum_last    = (idx_q == SWEEP_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      throttle_off_q <= 1'b0;
      override_q     <= '0;
      minimum_q      <= MINIMUM_RESET;
      adaptive_q     <= MINIMUM_RESET;
      for (int i = 0; i < SLOTS; i++) begin
        res_mem[i] <= '0;
        sch_mem[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (wtca_reg_e'(cfg_index_i))
          REG_THROTTLE_OFF:   throttle_off_q <= cfg_data_i[0];
          REG_LIMIT_OVERRIDE: override_q     <= cfg_data_i;
          REG_LIMIT_MINIMUM:  minimum_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.apply_limit) begin
        adaptive_q <= lim_new;
      end
      if (cmd_i.update) begin
        unique case (type_q)
          REQ_RESERVE: begin
            if (throttle_off_q || !refuse) begin
              res_mem[slot_q] <= res_plus;
            end
          end
          REQ_RELEASE: begin
            res_mem[slot_q] <= res_minus;
          end
          REQ_SCHEDULE: begin
            if (amount_q != '0) begin
              sch_mem[slot_q] <= sch_plus;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      type_q    <= wtca_req_e'(req_type_i);
      slot_q    <= SW'(slot_mod);
      amount_q  <= amount_i;
      refused_q <= 1'b0;
      delay_q   <= 1'b0;
    end
    if (cmd_i.load) begin
      res_q   <= rd_res;
      sch_q   <= rd_sch;
      lim_q   <= (override_q != '0) ? override_q : adaptive_q;
      idx_q   <= '0;
      total_q <= '0;
    end
    if (cmd_i.calc) begin
      usage_q <= sat_add(sch_q, {1'b0, res_q[CNT_W-1:1]});
      lim78_q <= lim_q - {3'b000, lim_q[AMT_W-1:3]};
    end
    if (cmd_i.update && type_q == REQ_RESERVE && !throttle_off_q) begin
      refused_q <= refuse;
      delay_q   <= !refuse && delay;
    end
    if (cmd_i.sum_step) begin
      total_q <= sat_add(total_q, sweep_val);
      idx_q   <= idx_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_refused_q <= refused_q;
      out_delay_q   <= delay_q;
      out_limit_q   <= adaptive_q;
    end
  end

  assign refused_o       = out_refused_q;
  assign delay_tick_o    = out_delay_q;
  assign current_limit_o = out_limit_q;

endmodule

`default_nettype wire

/* hw/rtl/write_throttle_credit_accounting_unit.sv */
// Top level of the write throttle credit accounting unit.
// Joins the sequencer wtca_ctrl and the datapath wtca_dp; uses wtca_pkg.
//
// Requests enter on the s_axis group: tuser carries the request type and
// the group slot, tdata the byte amount. Each request returns one result
// on the m_axis group: tuser carries the refused and delay flags, tdata
// the adaptive write limit after the request. Configuration writes use
// the cfg channel (index 0 throttle off, 1 limit override, 2 limit
// minimum) and are always taken.
// One request is handled at a time by the sequencer. Reserve, release and
// schedule requests read the slot counters, form the usage and write back.
// Memory pressure sweeps all counters through one saturating adder, one
// counter a cycle, then sets the new limit; it skips the sweep when the
// limit already sits at its minimum.
// Reset clears all slot counters and sets the adaptive limit and the limit
// minimum to 33554432. A stalled receiver holds the result in the output
// register; the next request is still taken and, once done, waits in the
// sequencer until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module write_throttle_credit_accounting_unit
  import wtca_pkg::*;
#(
  parameter int unsigned SLOTS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [47:0]          s_axis_tdata,  // amount[47:0]
  input  wire logic [3:0]           s_axis_tuser,  // req_type[1:0], group_slot[3:2]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [47:0]               m_axis_tdata,  // current_limit[47:0]
  output logic [1:0]                m_axis_tuser,  // refused[0], delay_tick[1]
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [AMT_W-1:0]     cfg_data_i
);

  wtca_cmd_t  cmd;
  wtca_stat_t stat;
  logic       refused, delay_tick;

  assign cfg_ready_o = 1'b1;

  wtca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wtca_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (s_axis_tuser[1:0]),
    .group_slot_i    (s_axis_tuser[3:2]),
    .amount_i        (s_axis_tdata),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .refused_o       (refused),
    .delay_tick_o    (delay_tick),
    .current_limit_o (m_axis_tdata)
  );

  assign m_axis_tuser = {delay_tick, refused};

endmodule

`default_nettype wire
